/* rtl/i2c_master_byte_engine_assert.svh */
// Assertion macros for the I2C master byte engine.
// Concurrent checks clocked on clk and disabled during arst_n.
`ifndef I2C_MASTER_BYTE_ENGINE_ASSERT_SVH
`define I2C_MASTER_BYTE_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication check
`define I2CM_ASSERT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
else $error("i2cm assertion failed");
// Next-cycle implication check
`define I2CM_ASSERT_NXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
else $error("i2cm assertion failed");
`else
`define I2CM_ASSERT(lbl, ante, cons)
`define I2CM_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* rtl/i2cm_pkg.sv */
// Shared types and constants for the I2C master byte engine.
// No dependencies.
package i2cm_pkg;

	localparam int BYTE_BITS = 8;
	localparam int UNIT_W    = 16;
	localparam int BIDX_W    = 4;

	localparam logic [UNIT_W-1:0] UNIT_RESET = 16'd100;

	// Register index of the timing unit
	localparam logic REG_UNIT_TICKS = 1'b0;

	typedef enum logic [2:0] {
		FN_NONE  = 3'd0,
		FN_START = 3'd1,
		FN_WRITE = 3'd2,
		FN_READ  = 3'd3,
		FN_STOP  = 3'd4
	} func_t;

	typedef enum logic [24:0] {
		PH_IDLE_BUS  = 25'h0000001,
		PH_IDLE_HELD = 25'h0000002,
		PH_ST_A_HI   = 25'h0000004,
		PH_ST_A_LO   = 25'h0000008,
		PH_ST_B      = 25'h0000010,
		PH_ST_C      = 25'h0000020,
		PH_ST_D1     = 25'h0000040,
		PH_ST_D2     = 25'h0000080,
		PH_SP_A      = 25'h0000100,
		PH_SP_B      = 25'h0000200,
		PH_SP_C      = 25'h0000400,
		PH_WB_SET    = 25'h0000800,
		PH_WB_HI1    = 25'h0001000,
		PH_WB_HI2    = 25'h0002000,
		PH_WB_LOW    = 25'h0004000,
		PH_WA_SET    = 25'h0008000,
		PH_WA_HI     = 25'h0010000,
		PH_WA_LOW    = 25'h0020000,
		PH_RB_LO1    = 25'h0040000,
		PH_RB_LO2    = 25'h0080000,
		PH_RB_HI1    = 25'h0100000,
		PH_RB_HI2    = 25'h0200000,
		PH_MA_SET    = 25'h0400000,
		PH_MA_HI     = 25'h0800000,
		PH_MA_LOW    = 25'h1000000
	} phase_t;

	// Result item, scl in bit 0
	typedef struct packed {
		logic                 nack;
		logic [BYTE_BITS-1:0] rx_byte;
		logic                 done_res;
		logic                 busy_res;
		logic                 sda_level;
		logic                 scl_level;
	} res_t;

endpackage

/* rtl/i2c_master_byte_engine.sv */
// I2C master byte engine: one stream transaction is one bus tick.
// A result is computed from its input transaction and registered in the output stage when the transaction is accepted.
// Throughput: one transaction per cycle while the skid is empty; a two-entry output stage
// (register plus skid) keeps accepting while one result waits.
// Reset: arst_n clears the sequencer to idle with the bus free and unit_ticks to 100.
// Depends on i2cm_pkg and i2c_master_byte_engine_assert.svh.
`include "i2c_master_byte_engine_assert.svh"

module i2c_master_byte_engine import i2cm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // func[2:0], tx_byte[10:3], master_ack[11], sda_in[12]
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // scl_level[0], sda_level[1], busy_res[2], done_res[3],
	                               // rx_byte[11:4], nack[12]
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int RES_W = $bits(res_t);

	// sequencer state
	phase_t                phase_q;
	logic [UNIT_W-1:0]     tick_q;
	logic [BIDX_W-1:0]     bit_q;
	logic [BYTE_BITS-1:0]  shift_q;
	logic [BYTE_BITS-1:0]  rx_q;
	logic                  nack_q;
	logic                  ack_q;
	logic [UNIT_W-1:0]     unit_q;

	phase_t                phase_d;
	logic [UNIT_W-1:0]     tick_d;
	logic [BIDX_W-1:0]     bit_d;
	logic [BYTE_BITS-1:0]  shift_d;
	logic [BYTE_BITS-1:0]  rx_d;
	logic                  nack_d;
	logic                  ack_d;
	logic                  done_d;
	logic [BIDX_W-1:0]     bit_inc;
	logic [BYTE_BITS-1:0]  shift_rd;

	// output register and skid
	res_t                  out_q;
	res_t                  skid_q;
	logic                  out_v_q;
	logic                  skid_v_q;
	res_t                  res_d;

	logic                  accept;
	logic                  out_fire;
	logic                  held;
	logic                  idle_w;
	logic [UNIT_W-1:0]     unit_m1;
	func_t                 func;
	logic [BYTE_BITS-1:0]  tx_byte;
	logic                  master_ack;
	logic                  sda_in;

	assign func       = func_t'(s_tdata[2:0]);
	assign tx_byte    = s_tdata[10:3];
	assign master_ack = s_tdata[11];
	assign sda_in     = s_tdata[12];

	assign s_tready = !skid_v_q;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_v_q;
	assign out_fire = out_v_q && m_tready;
	assign m_tdata  = {{(16-RES_W){1'b0}}, out_q};

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_UNIT_TICKS) ? {{(32-UNIT_W){1'b0}}, unit_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q <= UNIT_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_UNIT_TICKS) begin
			unit_q <= pwdata[UNIT_W-1:0];
		end
	end

	assign idle_w  = (phase_q == PH_IDLE_BUS) || (phase_q == PH_IDLE_HELD);
	assign held    = (phase_q == PH_IDLE_HELD);
	// a zero unit acts as one tick
	assign unit_m1 = (unit_q == '0) ? '0 : unit_q - UNIT_W'(1);
	assign bit_inc = bit_q + BIDX_W'(1);
	assign shift_rd = {shift_q[BYTE_BITS-2:0], sda_in};

	// next state for one tick
	always_comb begin
		phase_d = phase_q;
		tick_d  = tick_q;
		bit_d   = bit_q;
		shift_d = shift_q;
		rx_d    = rx_q;
		nack_d  = nack_q;
		ack_d   = ack_q;
		done_d  = 1'b0;
		if (idle_w) begin
			case (func)
				FN_START: begin
					phase_d = held ? PH_ST_A_LO : PH_ST_A_HI;
					tick_d  = unit_m1;
				end
				FN_WRITE: begin
					if (held) begin
						shift_d = tx_byte;
						bit_d   = '0;
						phase_d = PH_WB_SET;
						tick_d  = unit_m1;
					end else begin
						nack_d = 1'b1;
						done_d = 1'b1;
					end
				end
				FN_READ: begin
					if (held) begin
						shift_d = '0;
						bit_d   = '0;
						ack_d   = master_ack;
						phase_d = PH_RB_LO1;
						tick_d  = unit_m1;
					end else begin
						done_d = 1'b1;
					end
				end
				FN_STOP: begin
					if (held) begin
						phase_d = PH_SP_A;
						tick_d  = unit_m1;
					end else begin
						done_d = 1'b1;
					end
				end
				default: ;
			endcase
		end else if (tick_q != '0) begin
			tick_d = tick_q - UNIT_W'(1);
		end else begin
			tick_d = unit_m1;
			case (phase_q)
				PH_ST_A_HI, PH_ST_A_LO: phase_d = PH_ST_B;
				PH_ST_B:   phase_d = PH_ST_C;
				PH_ST_C:   phase_d = PH_ST_D1;
				PH_ST_D1:  phase_d = PH_ST_D2;
				PH_SP_A:   phase_d = PH_SP_B;
				PH_SP_B:   phase_d = PH_SP_C;
				PH_WB_SET: phase_d = PH_WB_HI1;
				PH_WB_HI1: phase_d = PH_WB_HI2;
				PH_WB_HI2: phase_d = PH_WB_LOW;
				PH_WB_LOW: begin
					shift_d = {shift_q[BYTE_BITS-2:0], 1'b0};
					bit_d   = bit_inc;
					phase_d = (bit_inc >= BIDX_W'(BYTE_BITS)) ? PH_WA_SET : PH_WB_SET;
				end
				PH_WA_SET: phase_d = PH_WA_HI;
				PH_WA_HI: begin
					nack_d  = sda_in;
					phase_d = PH_WA_LOW;
				end
				PH_RB_LO1: phase_d = PH_RB_LO2;
				PH_RB_LO2: phase_d = PH_RB_HI1;
				PH_RB_HI1: phase_d = PH_RB_HI2;
				PH_RB_HI2: begin
					shift_d = shift_rd;
					bit_d   = bit_inc;
					if (bit_inc >= BIDX_W'(BYTE_BITS)) begin
						rx_d    = shift_rd;
						phase_d = PH_MA_SET;
					end else begin
						phase_d = PH_RB_LO1;
					end
				end
				PH_MA_SET: phase_d = PH_MA_HI;
				PH_MA_HI:  phase_d = PH_MA_LOW;
				PH_ST_D2, PH_WA_LOW, PH_MA_LOW: begin
					phase_d = PH_IDLE_HELD;
					tick_d  = '0;
					done_d  = 1'b1;
				end
				default: begin
					phase_d = PH_IDLE_BUS;
					tick_d  = '0;
					done_d  = 1'b1;
				end
			endcase
		end
	end

	// line drive and status of the new state
	always_comb begin
		res_d           = '0;
		res_d.busy_res  = !((phase_d == PH_IDLE_BUS) || (phase_d == PH_IDLE_HELD));
		res_d.done_res  = done_d;
		res_d.rx_byte   = rx_d;
		res_d.nack      = nack_d;
		case (phase_d)
			PH_IDLE_BUS, PH_ST_A_HI, PH_ST_B, PH_SP_C, PH_WA_HI, PH_RB_HI1,
			PH_RB_HI2: begin
				res_d.scl_level = 1'b1;
				res_d.sda_level = 1'b1;
			end
			PH_IDLE_HELD, PH_ST_A_LO, PH_WA_SET, PH_WA_LOW, PH_RB_LO1,
			PH_RB_LO2: begin
				res_d.scl_level = 1'b0;
				res_d.sda_level = 1'b1;
			end
			PH_ST_C, PH_SP_B: begin
				res_d.scl_level = 1'b1;
				res_d.sda_level = 1'b0;
			end
			PH_ST_D1, PH_ST_D2, PH_SP_A: begin
				res_d.scl_level = 1'b0;
				res_d.sda_level = 1'b0;
			end
			PH_WB_SET, PH_WB_LOW: begin
				res_d.scl_level = 1'b0;
				res_d.sda_level = shift_d[BYTE_BITS-1];
			end
			PH_WB_HI1, PH_WB_HI2: begin
				res_d.scl_level = 1'b1;
				res_d.sda_level = shift_d[BYTE_BITS-1];
			end
			PH_MA_SET, PH_MA_LOW: begin
				res_d.scl_level = 1'b0;
				res_d.sda_level = !ack_d;
			end
			PH_MA_HI: begin
				res_d.scl_level = 1'b1;
				res_d.sda_level = !ack_d;
			end
			default: begin
				res_d.scl_level = 1'b1;
				res_d.sda_level = 1'b1;
			end
		endcase
	end

	// advance the sequencer on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE_BUS;
			tick_q  <= '0;
			bit_q   <= '0;
			shift_q <= '0;
			rx_q    <= '0;
			nack_q  <= 1'b0;
			ack_q   <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			rx_q    <= rx_d;
			nack_q  <= nack_d;
			ack_q   <= ack_d;
		end
	end

	// output valid flags: load output, spill to skid, drain skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (skid_v_q) begin
				if (out_fire) begin
					skid_v_q <= 1'b0;
				end
			end else if (accept) begin
				if (out_v_q && !m_tready) begin
					skid_v_q <= 1'b1;
				end else begin
					out_v_q <= 1'b1;
				end
			end else if (out_fire) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (out_fire) begin
				out_q <= skid_q;
			end
		end else if (accept) begin
			if (out_v_q && !m_tready) begin
				skid_q <= res_d;
			end else begin
				out_q <= res_d;
			end
		end
	end

	`I2CM_ASSERT(a_skid_needs_out, skid_v_q, out_v_q)
	`I2CM_ASSERT_NXT(a_stalled_out_kept, out_v_q && !m_tready, out_v_q)
	`I2CM_ASSERT(a_idle_no_count, idle_w, tick_q == '0)
	`I2CM_ASSERT(a_bit_index_range, 1'b1, bit_q <= BIDX_W'(BYTE_BITS))

endmodule

/* dv/tb_i2c_master_byte_engine.sv */
// Self-checking testbench for the I2C master byte engine: drives bus ticks on the input
// stream, predicts every result transaction and compares it field by field.
// Depends on i2cm_pkg and the i2c_master_byte_engine RTL.
module tb_i2c_master_byte_engine;
	import i2cm_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam logic [2:0] UNIT_ADDR = {REG_UNIT_TICKS, 2'b00};

	localparam res_t R_IDLE_FREE = '{nack: 1'b0, rx_byte: 8'h00, done_res: 1'b0,
		busy_res: 1'b0, sda_level: 1'b1, scl_level: 1'b1};
	localparam res_t R_IDLE_NACK = '{nack: 1'b1, rx_byte: 8'h00, done_res: 1'b0,
		busy_res: 1'b0, sda_level: 1'b1, scl_level: 1'b1};
	localparam res_t R_DONE_FREE = '{nack: 1'b0, rx_byte: 8'h00, done_res: 1'b1,
		busy_res: 1'b0, sda_level: 1'b1, scl_level: 1'b1};
	localparam res_t R_DONE_NACK = '{nack: 1'b1, rx_byte: 8'h00, done_res: 1'b1,
		busy_res: 1'b0, sda_level: 1'b1, scl_level: 1'b1};

	// Directed row: either a unit register write or one command followed by bus ticks
	typedef struct packed {
		logic        cfg;
		logic [15:0] unit;
		logic [2:0]  fn;
		logic [7:0]  tx;
		logic        mk;
		logic        sd;
		logic        typed;
		res_t        want;
	} dir_row_t;

	localparam dir_row_t DIR_ROWS [23] = '{
		'{1'b0, 16'd0,     FN_NONE,  8'h00, 1'b0, 1'b0, 1'b1, R_IDLE_FREE},
		'{1'b0, 16'd0,     3'd7,     8'hff, 1'b1, 1'b1, 1'b1, R_IDLE_FREE},
		'{1'b0, 16'd0,     3'd5,     8'h00, 1'b0, 1'b0, 1'b1, R_IDLE_FREE},
		'{1'b0, 16'd0,     FN_READ,  8'h00, 1'b1, 1'b0, 1'b1, R_DONE_FREE},
		'{1'b0, 16'd0,     FN_STOP,  8'h00, 1'b0, 1'b1, 1'b1, R_DONE_FREE},
		'{1'b0, 16'd0,     FN_WRITE, 8'hff, 1'b0, 1'b0, 1'b1, R_DONE_NACK},
		'{1'b0, 16'd0,     3'd6,     8'h5a, 1'b1, 1'b0, 1'b1, R_IDLE_NACK},
		'{1'b1, 16'hffff,  FN_NONE,  8'h00, 1'b0, 1'b0, 1'b0, R_IDLE_FREE},
		'{1'b0, 16'd0,     FN_WRITE, 8'h00, 1'b1, 1'b1, 1'b1, R_DONE_NACK},
		'{1'b0, 16'd0,     FN_STOP,  8'h00, 1'b0, 1'b0, 1'b1, R_DONE_NACK},
		'{1'b1, 16'd0,     FN_NONE,  8'h00, 1'b0, 1'b0, 1'b0, R_IDLE_FREE},
		'{1'b0, 16'd0,     FN_START, 8'h00, 1'b0, 1'b0, 1'b0, R_IDLE_FREE},
		'{1'b0, 16'd0,     FN_WRITE, 8'hff, 1'b0, 1'b0, 1'b0, R_IDLE_FREE},
		'{1'b0, 16'd0,     FN_WRITE, 8'h00, 1'b0, 1'b1, 1'b0, R_IDLE_FREE},
		'{1'b0, 16'd0,     FN_READ,  8'h00, 1'b1, 1'b1, 1'b0, R_IDLE_FREE},
		'{1'b0, 16'd0,     FN_READ,  8'hff, 1'b0, 1'b0, 1'b0, R_IDLE_FREE},
		'{1'b0, 16'd0,     FN_START, 8'h00, 1'b0, 1'b0, 1'b0, R_IDLE_FREE},
		'{1'b1, 16'd2,     FN_NONE,  8'h00, 1'b0, 1'b0, 1'b0, R_IDLE_FREE},
		'{1'b0, 16'd0,     FN_WRITE, 8'ha5, 1'b0, 1'b0, 1'b0, R_IDLE_FREE},
		'{1'b0, 16'd0,     FN_READ,  8'h00, 1'b0, 1'b1, 1'b0, R_IDLE_FREE},
		'{1'b0, 16'd0,     FN_STOP,  8'h00, 1'b0, 1'b0, 1'b0, R_IDLE_FREE},
		'{1'b0, 16'd0,     FN_READ,  8'h00, 1'b1, 1'b0, 1'b0, R_IDLE_FREE},
		'{1'b1, 16'd1,     FN_NONE,  8'h00, 1'b0, 1'b0, 1'b0, R_IDLE_FREE}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // func[2:0], tx_byte[10:3], master_ack[11], sda_in[12]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // scl_level[0], sda_level[1], busy_res[2], done_res[3],
	                             // rx_byte[11:4], nack[12]
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// Predicted engine state and timing unit
	phase_t      ph = PH_IDLE_BUS;
	logic [15:0] tcnt = '0;
	logic [3:0]  bidx = '0;
	logic [7:0]  shreg = '0;
	logic [7:0]  rxreg = '0;
	logic        nackf = 1'b0;
	logic        ackc = 1'b0;
	logic [15:0] unit_cfg = UNIT_RESET;

	res_t        bus_expect_q [$];
	int          mismatch_cnt = 0;
	int          n_results = 0;
	int          n_ticks = 0;
	int          n_start = 0;
	int          n_write = 0;
	int          n_read = 0;
	int          n_stop = 0;
	int          n_unit_writes = 0;
	int          burst_left = 0;
	logic [31:0] rcv_cycle = '0;
	int          stall_cycles = 0;

	i2c_master_byte_engine i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #5 clk = ~clk;

	function automatic logic pred_idle();
		return ph == PH_IDLE_BUS || ph == PH_IDLE_HELD;
	endfunction

	function automatic void phase_enter(phase_t p);
		ph = p;
		tcnt = ((unit_cfg == 16'd0) ? 16'd1 : unit_cfg) - 16'd1;
	endfunction

	function automatic void phase_park(phase_t p);
		ph = p;
		tcnt = '0;
	endfunction

	// Advance the predicted engine by one bus tick and return the result it shows
	function automatic res_t engine_tick(logic [2:0] fn, logic [7:0] tx, logic mk, logic sd);
		res_t r;
		logic fin;
		logic held;
		fin = 1'b0;
		held = (ph == PH_IDLE_HELD);
		if (pred_idle()) begin
			case (fn)
				FN_START: phase_enter(held ? PH_ST_A_LO : PH_ST_A_HI);
				FN_WRITE: begin
					if (held) begin
						shreg = tx;
						bidx = '0;
						phase_enter(PH_WB_SET);
					end else begin
						nackf = 1'b1;
						fin = 1'b1;
					end
				end
				FN_READ: begin
					if (held) begin
						shreg = '0;
						bidx = '0;
						ackc = mk;
						phase_enter(PH_RB_LO1);
					end else begin
						fin = 1'b1;
					end
				end
				FN_STOP: begin
					if (held)
						phase_enter(PH_SP_A);
					else
						fin = 1'b1;
				end
				default: ;
			endcase
		end else if (tcnt != 16'd0) begin
			tcnt = tcnt - 16'd1;
		end else begin
			case (ph)
				PH_ST_A_HI, PH_ST_A_LO: phase_enter(PH_ST_B);
				PH_ST_B:   phase_enter(PH_ST_C);
				PH_ST_C:   phase_enter(PH_ST_D1);
				PH_ST_D1:  phase_enter(PH_ST_D2);
				PH_ST_D2: begin
					phase_park(PH_IDLE_HELD);
					fin = 1'b1;
				end
				PH_SP_A:   phase_enter(PH_SP_B);
				PH_SP_B:   phase_enter(PH_SP_C);
				PH_SP_C: begin
					phase_park(PH_IDLE_BUS);
					fin = 1'b1;
				end
				PH_WB_SET: phase_enter(PH_WB_HI1);
				PH_WB_HI1: phase_enter(PH_WB_HI2);
				PH_WB_HI2: phase_enter(PH_WB_LOW);
				PH_WB_LOW: begin
					shreg = {shreg[6:0], 1'b0};
					bidx = bidx + 4'd1;
					phase_enter((bidx >= BYTE_BITS) ? PH_WA_SET : PH_WB_SET);
				end
				PH_WA_SET: phase_enter(PH_WA_HI);
				PH_WA_HI: begin
					nackf = sd;
					phase_enter(PH_WA_LOW);
				end
				PH_WA_LOW: begin
					phase_park(PH_IDLE_HELD);
					fin = 1'b1;
				end
				PH_RB_LO1: phase_enter(PH_RB_LO2);
				PH_RB_LO2: phase_enter(PH_RB_HI1);
				PH_RB_HI1: phase_enter(PH_RB_HI2);
				PH_RB_HI2: begin
					shreg = {shreg[6:0], sd};
					bidx = bidx + 4'd1;
					if (bidx >= BYTE_BITS) begin
						rxreg = shreg;
						phase_enter(PH_MA_SET);
					end else begin
						phase_enter(PH_RB_LO1);
					end
				end
				PH_MA_SET: phase_enter(PH_MA_HI);
				PH_MA_HI:  phase_enter(PH_MA_LOW);
				PH_MA_LOW: begin
					phase_park(PH_IDLE_HELD);
					fin = 1'b1;
				end
				default: begin
					phase_park(PH_IDLE_BUS);
					fin = 1'b1;
				end
			endcase
		end

		// Line drive for the phase now held
		case (ph)
			PH_IDLE_BUS, PH_ST_A_HI, PH_ST_B, PH_SP_C,
			PH_WA_HI, PH_RB_HI1, PH_RB_HI2: begin
				r.scl_level = 1'b1;
				r.sda_level = 1'b1;
			end
			PH_IDLE_HELD, PH_ST_A_LO, PH_WA_SET, PH_WA_LOW, PH_RB_LO1, PH_RB_LO2: begin
				r.scl_level = 1'b0;
				r.sda_level = 1'b1;
			end
			PH_ST_C, PH_SP_B: begin
				r.scl_level = 1'b1;
				r.sda_level = 1'b0;
			end
			PH_ST_D1, PH_ST_D2, PH_SP_A: begin
				r.scl_level = 1'b0;
				r.sda_level = 1'b0;
			end
			PH_WB_SET, PH_WB_LOW: begin
				r.scl_level = 1'b0;
				r.sda_level = shreg[7];
			end
			PH_WB_HI1, PH_WB_HI2: begin
				r.scl_level = 1'b1;
				r.sda_level = shreg[7];
			end
			PH_MA_SET, PH_MA_LOW: begin
				r.scl_level = 1'b0;
				r.sda_level = ~ackc;
			end
			PH_MA_HI: begin
				r.scl_level = 1'b1;
				r.sda_level = ~ackc;
			end
			default: begin
				r.scl_level = 1'b1;
				r.sda_level = 1'b1;
			end
		endcase
		r.busy_res = ~pred_idle();
		r.done_res = fin;
		r.rx_byte = rxreg;
		r.nack = nackf;
		return r;
	endfunction

	function automatic logic [7:0] rand_byte();
		int roll;
		roll = $urandom_range(9);
		if (roll == 0)
			return 8'h00;
		else if (roll == 1)
			return 8'hff;
		return 8'($urandom);
	endfunction

	task automatic report_mismatch(string field, int got, int want);
		$display("MISMATCH %s: got 0x%0h, expected 0x%0h (result %0d)",
			field, got, want, n_results);
		mismatch_cnt++;
	endtask

	task automatic check_result(res_t got);
		res_t want;
		n_results++;
		if (bus_expect_q.size() == 0) begin
			report_mismatch("unexpected result", int'(got), 0);
		end else begin
			want = bus_expect_q.pop_front();
			if (got.scl_level !== want.scl_level)
				report_mismatch("scl_level", int'(got.scl_level), int'(want.scl_level));
			if (got.sda_level !== want.sda_level)
				report_mismatch("sda_level", int'(got.sda_level), int'(want.sda_level));
			if (got.busy_res !== want.busy_res)
				report_mismatch("busy_res", int'(got.busy_res), int'(want.busy_res));
			if (got.done_res !== want.done_res)
				report_mismatch("done_res", int'(got.done_res), int'(want.done_res));
			if (got.rx_byte !== want.rx_byte)
				report_mismatch("rx_byte", int'(got.rx_byte), int'(want.rx_byte));
			if (got.nack !== want.nack)
				report_mismatch("nack", int'(got.nack), int'(want.nack));
		end
	endtask

	// Send one bus tick in bursts with random gaps, then predict its result
	task automatic bus_item(logic [2:0] fn, logic [7:0] tx, logic mk, logic sd,
			logic typed, res_t want);
		int gap;
		res_t r;
		if (burst_left == 0) begin
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
			burst_left = ($urandom_range(7) == 0) ? $urandom_range(300, 100)
				: $urandom_range(24, 1);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tdata <= {3'b000, sd, mk, tx, fn};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		if (pred_idle()) begin
			case (fn)
				FN_START: n_start++;
				FN_WRITE: n_write++;
				FN_READ:  n_read++;
				FN_STOP:  n_stop++;
				default: ;
			endcase
		end
		r = engine_tick(fn, tx, mk, sd);
		bus_expect_q.push_back(typed ? want : r);
		n_ticks++;
	endtask

	// Hold the input stream until every expected result has arrived
	task automatic drain_results();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (bus_expect_q.size() != 0) @(posedge clk);
	endtask

	// Optionally write the unit register, then read it back
	task automatic unit_reg(logic wr, logic [15:0] val);
		if (wr) begin
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b1;
			paddr <= UNIT_ADDR;
			pwdata <= 32'(val);
			@(posedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
			unit_cfg = val;
			n_unit_writes++;
		end
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= UNIT_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[15:0] !== unit_cfg)
			report_mismatch("unit_ticks readback", int'(prdata[15:0]), int'(unit_cfg));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Mostly well-formed bus transfers with random data, plus noise and refused commands
	task automatic random_phase(int tick_target);
		int ticks;
		int roll;
		logic after_start;
		logic [2:0] fn;
		ticks = 0;
		after_start = 1'b0;
		while (ticks < tick_target) begin
			roll = $urandom_range(99);
			if (!pred_idle()) begin
				fn = (roll < 15) ? 3'($urandom_range(7)) : FN_NONE;
				bus_item(fn, rand_byte(), 1'($urandom), 1'($urandom), 1'b0, R_IDLE_FREE);
				ticks++;
			end else if (roll < 8) begin
				fn = (roll < 4) ? FN_NONE : 3'($urandom_range(7, 5));
				bus_item(fn, rand_byte(), 1'($urandom), 1'($urandom), 1'b0, R_IDLE_FREE);
			end else begin
				if (ph == PH_IDLE_BUS)
					fn = (roll < 90) ? FN_START : 3'($urandom_range(4, 2));
				else if (after_start)
					fn = (roll < 92) ? FN_WRITE : 3'($urandom_range(4, 1));
				else if (roll < 50)
					fn = FN_WRITE;
				else if (roll < 78)
					fn = FN_READ;
				else if (roll < 92)
					fn = FN_STOP;
				else
					fn = FN_START;
				after_start = (fn == FN_START);
				bus_item(fn, rand_byte(), 1'($urandom), 1'($urandom), 1'b0, R_IDLE_FREE);
				ticks++;
			end
		end
	endtask

	// Check results and stall the result stream on a pattern of its own
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_result(res_t'(m_tdata[12:0]));
		rcv_cycle <= rcv_cycle + 32'd1;
		case (rcv_cycle[9:8])
			2'd0: m_tready <= 1'b1;
			2'd1: m_tready <= ($urandom_range(3) != 0);
			2'd2: m_tready <= ((rcv_cycle % 7) != 3);
			default: m_tready <= ($urandom_range(9) < 4);
		endcase
	end

	// End the run when no transaction moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (psel && penable && pready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog: no transaction for %0d cycles, %0d results pending",
					WATCHDOG_LIMIT, bus_expect_q.size());
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		unit_reg(1'b0, 16'd0);

		// Walk the directed rows, running the bus clock until the engine idles
		for (int i = 0; i < $size(DIR_ROWS); i++) begin
			if (DIR_ROWS[i].cfg) begin
				drain_results();
				unit_reg(1'b1, DIR_ROWS[i].unit);
			end else begin
				bus_item(DIR_ROWS[i].fn, DIR_ROWS[i].tx, DIR_ROWS[i].mk, DIR_ROWS[i].sd,
					DIR_ROWS[i].typed, DIR_ROWS[i].want);
				while (!pred_idle())
					bus_item(FN_NONE, rand_byte(), 1'($urandom), DIR_ROWS[i].sd, 1'b0,
						R_IDLE_FREE);
			end
		end

		// Random traffic over several unit settings; writes may land mid-phase
		random_phase(350);
		drain_results();
		unit_reg(1'b1, 16'd0);
		random_phase(200);
		drain_results();
		unit_reg(1'b1, 16'($urandom_range(4, 2)));
		random_phase(300);
		drain_results();
		unit_reg(1'b1, 16'd1);
		random_phase(130);

		drain_results();
		repeat (20) @(posedge clk);
		$display("Ran %0d bus ticks, %0d results: %0d starts, %0d writes, %0d reads, %0d stops",
			n_ticks, n_results, n_start, n_write, n_read, n_stop);
		$display("Unit register written %0d times incl. 0 and 65535; %0d mismatches",
			n_unit_writes, mismatch_cnt);
		if (mismatch_cnt == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl
rtl/i2cm_pkg.sv
rtl/i2c_master_byte_engine.sv
dv/tb_i2c_master_byte_engine.sv
